/* rtl/sek_pkg.sv */
// Shared types and constants of the squared-exponential kernel block.
package sek_pkg;

    localparam int EXP_TABLE_DEPTH_DEF = 256;
    localparam int ACC_W               = 40;
    localparam int Q_DEPTH             = 4;

    localparam logic REG_SIGNAL_VARIANCE   = 1'b0;
    localparam logic REG_INV_TWO_LENGTH_SQ = 1'b1;

    localparam logic [31:0] SIGNAL_VARIANCE_RST   = 32'd16777216;
    localparam logic [31:0] INV_TWO_LENGTH_SQ_RST = 32'd8388608;

    typedef struct packed {
        logic signed [15:0] desc_a;
        logic signed [15:0] desc_b;
        logic [15:0]        norm_a;
        logic [15:0]        norm_b;
        logic [15:0]        cut_a;
        logic [15:0]        cut_b;
        logic               last_element;
    } t_item;

    typedef struct packed {
        logic [31:0] kernel_value;
    } t_result;

    typedef struct packed {
        logic signed [ACC_W-1:0] dot;
        logic [15:0]             norm_a;
        logic [15:0]             norm_b;
        logic [15:0]             cut_a;
        logic [15:0]             cut_b;
    } t_pair;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

/* rtl/sek_stream_if.sv */
// Valid/ready stream channel carrying one payload beat.
interface sek_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* rtl/sek_front.sv */
// Front end: accept element beats, run the dot-product MAC, hand off pairs.
module sek_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sek_stream_if.sink           i_item,
    input  sek_pkg::t_q_status   i_q,
    output logic                 o_push,
    output sek_pkg::t_pair       o_pair
);
    localparam int AW = sek_pkg::ACC_W;

    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] n_acc;
    logic signed [31:0]   prod;
    logic signed [AW:0]   sum;
    logic signed [AW-1:0] sat;
    logic                 accept;

    assign i_item.ready = !i_q.full;
    assign accept       = i_item.valid && i_item.ready;
    assign prod         = i_item.data.desc_a * i_item.data.desc_b;
    assign sum          = (AW+1)'(r_acc) + (AW+1)'(prod);

    // clamp to the signed accumulator range
    always_comb begin
        if (sum[AW] != sum[AW-1]) begin
            sat = sum[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end else begin
            sat = sum[AW-1:0];
        end
        n_acc = i_item.data.last_element ? '0 : sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (accept) begin
            r_acc <= n_acc;
        end
    end

    assign o_push        = accept && i_item.data.last_element;
    assign o_pair.dot    = sat;
    assign o_pair.norm_a = i_item.data.norm_a;
    assign o_pair.norm_b = i_item.data.norm_b;
    assign o_pair.cut_a  = i_item.data.cut_a;
    assign o_pair.cut_b  = i_item.data.cut_b;
endmodule

/* rtl/sek_queue.sv */
// Short pair queue between front and back.
module sek_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sek_pkg::t_pair     i_pair,
    input  logic               i_pop,
    output sek_pkg::t_pair     o_pair,
    output sek_pkg::t_q_status o_q
);
    localparam int D  = sek_pkg::Q_DEPTH;
    localparam int PW = $clog2(D);
    localparam int CW = $clog2(D + 1);

    sek_pkg::t_pair r_mem [D];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_q.full  = (r_cnt == CW'(D));
    assign o_q.empty = (r_cnt == '0);
    assign o_pair    = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(D - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(D - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_q.full || i_pop) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_q.empty) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(D)) else $error("queue count beyond depth");
`endif
endmodule

/* rtl/sek_back.sv */
// Back end: per-pair distance, exp table lookup and kernel scaling.
module sek_back #(
    parameter int EXP_TABLE_DEPTH = sek_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sek_pkg::t_q_status i_q,
    input  sek_pkg::t_pair     i_pair,
    output logic               o_pop,
    sek_stream_if.source       o_result,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    localparam int IW = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int PW = 29 + IW;
    localparam logic [3:0] LAST_STEP = 4'd9;

    typedef logic [30:0] t_tab [EXP_TABLE_DEPTH + 1];

    // exp(-32k/depth) in Q.30: series for exp(-u), then eight squarings
    function automatic t_tab build_tab();
        t_tab        tab;
        logic [63:0] u;
        logic [63:0] mag;
        logic [63:0] sum;
        logic [63:0] v;
        for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
            u   = (64'(k) << 27) / EXP_TABLE_DEPTH;
            mag = 64'd1 << 30;
            sum = mag;
            mag = ((mag * u) >> 30) / 1; sum = sum - mag;
            mag = ((mag * u) >> 30) / 2; sum = sum + mag;
            mag = ((mag * u) >> 30) / 3; sum = sum - mag;
            mag = ((mag * u) >> 30) / 4; sum = sum + mag;
            mag = ((mag * u) >> 30) / 5; sum = sum - mag;
            mag = ((mag * u) >> 30) / 6; sum = sum + mag;
            mag = ((mag * u) >> 30) / 7; sum = sum - mag;
            v = sum;
            for (int s = 0; s < 8; s++) begin
                v = (v * v) >> 30;
            end
            tab[k] = v[30:0];
        end
        return tab;
    endfunction

    localparam t_tab EXP_TAB = build_tab();

    logic [31:0] r_sv;
    logic [31:0] r_ils;
    logic        r_busy;
    logic [3:0]  r_cnt;
    logic        r_out_valid;
    logic [31:0] r_out;

    logic [31:0]        r_na2, r_nb2;
    logic [47:0]        r_svca;
    logic signed [39:0] r_dot;
    logic [15:0]        r_cb;
    logic [37:0]        r_dq;
    logic [48:0]        r_tsv;
    logic [52:0]        r_p1;
    logic [48:0]        r_p2;
    logic [33:0]        r_t;
    logic [28:0]        r_x;
    logic               r_xz;
    logic [PW-1:0]      r_pos;
    logic [30:0]        r_t0, r_t1;
    logic [28:0]        r_frac;
    logic [59:0]        r_dm;
    logic [30:0]        r_e;
    logic [47:0]        r_pa, r_pb;

    logic signed [42:0] n_d;
    logic [69:0]        n_xs;
    logic [IW-1:0]      n_idx;
    logic [65:0]        n_r;
    logic [31:0]        n_out;

    assign o_pop = !r_busy && !r_out_valid && !i_q.empty;

    always_comb begin
        n_d   = 43'($signed({1'b0, r_na2, 4'b0})) + 43'($signed({1'b0, r_nb2, 4'b0}))
              - (43'(r_dot) <<< 1);
        n_xs  = {r_p2, 21'b0} + 70'(r_p1);
        n_idx = r_pos[PW-1:29];
        n_r   = 66'({r_pa, 17'b0}) + 66'(r_pb);
        n_out = (|n_r[65:62]) ? 32'hFFFF_FFFF : n_r[61:30];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv  <= sek_pkg::SIGNAL_VARIANCE_RST;
            r_ils <= sek_pkg::INV_TWO_LENGTH_SQ_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sek_pkg::REG_SIGNAL_VARIANCE:   r_sv  <= i_cfg_data;
                sek_pkg::REG_INV_TWO_LENGTH_SQ: r_ils <= i_cfg_data;
                default:                        r_sv  <= r_sv;
            endcase
        end
    end

    // stage 1 loads on pop; later stages settle while the inputs hold
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_na2  <= 32'(i_pair.norm_a) * 32'(i_pair.norm_a);
            r_nb2  <= 32'(i_pair.norm_b) * 32'(i_pair.norm_b);
            r_svca <= 48'(r_sv) * 48'(i_pair.cut_a);
            r_dot  <= i_pair.dot;
            r_cb   <= i_pair.cut_b;
        end
        r_dq   <= n_d[42] ? '0 : n_d[41:4];
        r_tsv  <= 49'(r_svca[47:15]) * 49'(r_cb);
        r_p1   <= 53'(r_dq[20:0]) * 53'(r_ils);
        r_p2   <= 49'(r_dq[37:21]) * 49'(r_ils);
        r_t    <= r_tsv[48:15];
        r_x    <= n_xs[52:24];
        r_xz   <= |n_xs[69:53];
        r_pos  <= PW'(r_x) * PW'(EXP_TABLE_DEPTH);
        r_t0   <= EXP_TAB[n_idx];
        r_t1   <= EXP_TAB[n_idx + 1'b1];
        r_frac <= r_pos[28:0];
        r_dm   <= 60'(r_t0 - r_t1) * 60'(r_frac);
        r_e    <= r_xz ? '0 : r_t0 - r_dm[59:29];
        r_pa   <= 48'(r_t[33:17]) * 48'(r_e);
        r_pb   <= 48'(r_t[16:0]) * 48'(r_e);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd1;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy      <= 1'b0;
                    r_out_valid <= 1'b1;
                end
            end else if (r_out_valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && r_cnt == LAST_STEP) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.data.kernel_value = r_out;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_out_valid) else $error("result pending while busy");
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == LAST_STEP) |=> r_out_valid && !r_busy)
        else $error("finished pair not presented");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != 4'd0 && r_cnt <= LAST_STEP))
        else $error("step counter out of range");
`endif
endmodule

/* rtl/squared_exponential_energy_kernel.sv */
// Throughput: one element beat per cycle while the 4-entry pair queue is not full;
// a last beat pushes its pair, and the back end pops a new pair only once the
// current one is done (nine pipeline steps, the result beat, one pop).
// Reset: synchronous active-low i_rst_n clears the accumulator, the queue,
// the back-end control and restores both registers to their reset values.
module squared_exponential_energy_kernel #(
    parameter int EXP_TABLE_DEPTH = sek_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sek_stream_if.sink   i_item,
    sek_stream_if.source o_result,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    sek_pkg::t_q_status q_status;
    sek_pkg::t_pair     push_pair;
    sek_pkg::t_pair     head_pair;
    logic               push;
    logic               pop;

    // front: one MAC per accepted beat, push a pair on the last beat
    sek_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_q     (q_status),
        .o_push  (push),
        .o_pair  (push_pair)
    );

    // queue: decouple the streaming front from the per-pair back end
    sek_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (push_pair),
        .i_pop   (pop),
        .o_pair  (head_pair),
        .o_q     (q_status)
    );

    // back: distance, exp interpolation, amplitude and cutoff scaling
    sek_back #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q        (q_status),
        .i_pair     (head_pair),
        .o_pop      (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );
endmodule

/* dv/tb_squared_exponential_energy_kernel.sv */
// Testbench for the squared-exponential kernel block: directed and random stimulus, scoreboard.
`timescale 1ns / 1ps

module tb_squared_exponential_energy_kernel;

    localparam int          TABLE_DEPTH = 256;
    localparam longint      ACC_HI      = 64'sd549755813887;
    localparam longint      ACC_LO      = -64'sd549755813888;
    localparam int          HOLD_CYCLES = 500;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;

    sek_stream_if #(.t_payload(sek_pkg::t_item))   item_if();
    sek_stream_if #(.t_payload(sek_pkg::t_result)) result_if();

    squared_exponential_energy_kernel #(.EXP_TABLE_DEPTH(TABLE_DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if.sink),
        .o_result   (result_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Predictor state: its own copy of the registers, the running dot product
    // and the exp(-x) sample table.
    bit [31:0]         sig_var;
    bit [31:0]         inv_len;
    longint            dot_sum;
    longint unsigned   exp_samples[0:TABLE_DEPTH];

    sek_pkg::t_item    pending_beats[$];
    logic [31:0]       expected_kernels[$];

    int                fail_count;
    int                beats_sent;
    int                kernels_seen;
    int                saturated_seen;
    int                zero_seen;

    // Build exp(-32k/DEPTH) in Q.30: an 8-term series for exp(-u), then eight
    // squarings, all truncating.
    function automatic void build_exp_samples();
        longint unsigned u, mag, sum, v;
        for (int k = 0; k <= TABLE_DEPTH; k++) begin
            u   = (longint'(k) << 27) / TABLE_DEPTH;
            mag = 64'd1 << 30;
            sum = 64'd1 << 30;
            for (int n = 1; n <= 7; n++) begin
                mag = ((mag * u) >> 30) / n;
                if (n % 2 == 1) sum = sum - mag;
                else sum = sum + mag;
            end
            v = sum;
            for (int s = 0; s < 8; s++) v = (v * v) >> 30;
            exp_samples[k] = v & 64'hFFFF_FFFF;
        end
    endfunction

    // Interpolated exp(-x), x in Q.24, result in Q.30; zero from 32.0 up.
    function automatic longint unsigned exp_of_neg(longint unsigned x);
        longint unsigned pos, idx, frac, t0, t1;
        if (x >= (64'd32 << 24)) return 0;
        pos  = x * TABLE_DEPTH;
        idx  = pos >> 29;
        frac = pos & ((64'd1 << 29) - 1);
        if (idx >= TABLE_DEPTH) return 0;
        t0 = exp_samples[idx];
        t1 = exp_samples[idx + 1];
        return t0 - (((t0 - t1) * frac) >> 29);
    endfunction

    // Fold one accepted beat into the dot product; on a last beat queue the
    // kernel value it must produce and clear the sum.
    function automatic void accept_beat(sek_pkg::t_item it);
        longint          prod, d;
        longint unsigned dq24, x, e, t;
        logic [127:0]    wide;
        prod    = longint'(it.desc_a) * longint'(it.desc_b);
        dot_sum = dot_sum + prod;
        if (dot_sum > ACC_HI) dot_sum = ACC_HI;
        if (dot_sum < ACC_LO) dot_sum = ACC_LO;
        if (!it.last_element) return;
        d = (longint'(it.norm_a) * longint'(it.norm_a)) * 16
          + (longint'(it.norm_b) * longint'(it.norm_b)) * 16 - 2 * dot_sum;
        if (d < 0) d = 0;
        dq24 = longint'(d) >> 4;
        wide = 128'(dq24) * 128'(inv_len);
        x    = 64'(wide >> 24);
        e    = exp_of_neg(x);
        t    = (((longint'(sig_var) * longint'(it.cut_a)) >> 15) * longint'(it.cut_b)) >> 15;
        wide = 128'(t) * 128'(e);
        wide = wide >> 30;
        expected_kernels.push_back((wide > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0]);
        dot_sum = 0;
    endfunction

    function automatic sek_pkg::t_item make_beat(logic [15:0] a, logic [15:0] b, logic last,
                                                 logic [15:0] na, logic [15:0] nb,
                                                 logic [15:0] ca, logic [15:0] cb);
        sek_pkg::t_item it;
        it.desc_a       = a;
        it.desc_b       = b;
        it.norm_a       = na;
        it.norm_b       = nb;
        it.cut_a        = ca;
        it.cut_b        = cb;
        it.last_element = last;
        return it;
    endfunction

    // Queue one pair: len beats with random content, norms either small
    // (so the exponent lands inside the table) or anywhere in range.
    task automatic queue_random_pair(int len);
        logic [15:0] na, nb, ca, cb, a, b;
        int          mode;
        mode = $urandom_range(0, 3);
        na   = (mode == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192));
        nb   = (mode == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192));
        ca   = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        cb   = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
        for (int i = 0; i < len; i++) begin
            if (mode == 1) begin
                a = 16'($urandom_range(0, 4096) - 2048);
                b = a + 16'($urandom_range(0, 256) - 128);
            end else begin
                a = 16'($urandom);
                b = 16'($urandom);
            end
            pending_beats.push_back(make_beat(a, b, i == len - 1, na, nb, ca, cb));
        end
    endtask

    // Drain everything, give the back end time to settle, then write a register.
    task automatic write_reg(logic idx, logic [31:0] value);
        wait (pending_beats.size() == 0 && !item_if.valid && expected_kernels.size() == 0);
        repeat (30) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == sek_pkg::REG_SIGNAL_VARIANCE) sig_var = value;
        else inv_len = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random_pairs(int beats);
        int start;
        start = pending_beats.size();
        while (pending_beats.size() - start < beats) begin
            if ($urandom_range(0, 9) == 0) queue_random_pair($urandom_range(1, 40));
            else queue_random_pair($urandom_range(1, 6));
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

    // Driver: send queued beats in bursts of random length with random gaps.
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
            item_if.data  <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                accept_beat(item_if.data);
                beats_sent <= beats_sent + 1;
            end
            if (!item_if.valid || item_if.ready) begin
                if (gap_left > 0) begin
                    item_if.valid <= 1'b0;
                    gap_left      <= gap_left - 1;
                end else if (pending_beats.size() > 0) begin
                    item_if.data  <= pending_beats.pop_front();
                    item_if.valid <= 1'b1;
                    if (burst_left <= 1) begin
                        // Long bursts half the time so there are no-gap stretches too.
                        burst_left <= $urandom_range(0, 1) ? $urandom_range(20, 80)
                                                            : $urandom_range(1, 6);
                        gap_left   <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: rx_cycle sets when the stall pattern is redrawn; once, after 20 beats,
    // hold off for a long stretch so the pair queue fills and input stalls.
    int  stall_mode;
    int  rx_cycle;
    int  hold_left;
    bit  hold_done;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
            stall_mode      <= 0;
            rx_cycle        <= 0;
            hold_left       <= 0;
            hold_done       <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 63) stall_mode <= $urandom_range(0, 2);
            if (!hold_done && beats_sent >= 20) begin
                hold_done       <= 1'b1;
                hold_left       <= HOLD_CYCLES;
                result_if.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left       <= hold_left - 1;
                result_if.ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: begin
                        result_if.ready <= 1'b1;
                    end
                    1: begin
                        result_if.ready <= $urandom_range(0, 1);
                    end
                    default: begin
                        result_if.ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // Monitor: compare each accepted kernel value with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            kernels_seen <= kernels_seen + 1;
            if (result_if.data.kernel_value == 32'hFFFF_FFFF) saturated_seen <= saturated_seen + 1;
            if (result_if.data.kernel_value == 32'h0) zero_seen <= zero_seen + 1;
            if (expected_kernels.size() == 0) begin
                $error("kernel_value: expected none, actual %h", result_if.data.kernel_value);
                fail_count <= fail_count + 1;
            end else begin
                if (result_if.data.kernel_value !== expected_kernels[0]) begin
                    $error("kernel_value: expected %h, actual %h",
                           expected_kernels[0], result_if.data.kernel_value);
                    fail_count <= fail_count + 1;
                end
                void'(expected_kernels.pop_front());
            end
        end
    end

    initial begin
        int wait_cycles;
        fail_count     = 0;
        beats_sent     = 0;
        kernels_seen   = 0;
        saturated_seen = 0;
        zero_seen      = 0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = sek_pkg::REG_SIGNAL_VARIANCE;
        i_cfg_data     = '0;
        item_if.valid  = 1'b0;
        item_if.data   = '0;
        result_if.ready = 1'b0;
        sig_var        = sek_pkg::SIGNAL_VARIANCE_RST;
        inv_len        = sek_pkg::INV_TWO_LENGTH_SQ_RST;
        dot_sum        = 0;
        build_exp_samples();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, single-beat pairs, zero norms (exp of zero),
        // a negative squared distance, oversize weights.
        pending_beats.push_back(make_beat(16'h8000, 16'h8000, 1'b1, 0, 0, 16'h8000, 16'h8000));
        pending_beats.push_back(make_beat(16'h7FFF, 16'h8000, 1'b1, 0, 0, 16'h8000, 16'h8000));
        pending_beats.push_back(make_beat(16'h7FFF, 16'h7FFF, 1'b0, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(16'h4000, 16'h4000, 1'b1, 16'h1000, 16'h1000,
                                          16'h8000, 16'h8000));
        pending_beats.push_back(make_beat(0, 0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        pending_beats.push_back(make_beat(0, 0, 1'b1, 16'hFFFF, 0, 16'h8000, 16'h8000));
        pending_beats.push_back(make_beat(16'hFFFF, 16'h0001, 1'b1, 16'h2000, 16'h0800,
                                          16'hFFFF, 16'h4000));
        pending_beats.push_back(make_beat(16'h5555, 16'hAAAA, 1'b0, 0, 0, 0, 0));
        pending_beats.push_back(make_beat(16'hAAAA, 16'h5555, 1'b1, 16'h0100, 16'h0200,
                                          16'h7FFF, 16'h0001));
        pending_beats.push_back(make_beat(0, 0, 1'b1, 0, 0, 0, 0));
        run_random_pairs(100);

        // Saturate the dot product upward, then downward.
        write_reg(sek_pkg::REG_SIGNAL_VARIANCE, 32'hFFFF_FFFF);
        write_reg(sek_pkg::REG_INV_TWO_LENGTH_SQ, 32'h0);
        for (int i = 0; i < 520; i++)
            pending_beats.push_back(make_beat(16'h8000, 16'h8000, i == 519, 0, 0,
                                              16'h8000, 16'h8000));
        for (int i = 0; i < 520; i++)
            pending_beats.push_back(make_beat(16'h8000, 16'h7FFF, i == 519, 16'h0010, 0,
                                              16'hFFFF, 16'hFFFF));
        run_random_pairs(30);

        write_reg(sek_pkg::REG_SIGNAL_VARIANCE, 32'h0);
        write_reg(sek_pkg::REG_INV_TWO_LENGTH_SQ, 32'hFFFF_FFFF);
        run_random_pairs(30);

        write_reg(sek_pkg::REG_SIGNAL_VARIANCE, $urandom);
        write_reg(sek_pkg::REG_INV_TWO_LENGTH_SQ, $urandom_range(0, 32'h0400_0000));
        run_random_pairs(40);

        write_reg(sek_pkg::REG_SIGNAL_VARIANCE, 32'h0100_0000);
        write_reg(sek_pkg::REG_INV_TWO_LENGTH_SQ, $urandom_range(0, 32'h0010_0000));
        run_random_pairs(40);

        wait (pending_beats.size() == 0 && !item_if.valid);
        wait (expected_kernels.size() == 0);
        wait_cycles = 0;
        while (wait_cycles < 40) begin
            @(posedge i_clk);
            wait_cycles++;
        end

        $display("Run covered %0d element beats and %0d kernel values (%0d saturated, %0d zero)",
                 beats_sent, kernels_seen, saturated_seen, zero_seen);
        $display("across five register settings, accumulator saturation both ways and a long stall.");
        if (fail_count == 0 && expected_kernels.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
